### src/ttm_pkg.sv
// Shared types, constants and the elaboration-time thermistor table builder.
package ttm_pkg;

    typedef enum logic [2:0] {
        FN_SAMPLE    = 3'd0,
        FN_READ_TEMP = 3'd1,
        FN_READ_RAW  = 3'd2,
        FN_POLL      = 3'd3,
        FN_CLEAR     = 3'd4
    } t_func;

    localparam int FILT_W    = 20;
    localparam int DATA_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int PROD_W    = FILT_W + 1 + DATA_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b1;

    localparam logic [DATA_W-1:0] ALPHA_RST  = 16'd655;
    localparam logic [DATA_W-1:0] PERIOD_RST = 16'd100;

    localparam logic [7:0] EV_TEMP_CHANGE = 8'd0;

    localparam longint FILT_MAX_L = 524287;
    localparam longint FILT_MIN_L = -524288;
    localparam logic [63:0] LN2_Q30 = 64'd744261118;

    // log2 in unsigned Q.24: msb position, then one fraction bit per squaring
    function automatic logic [63:0] log2_q24(input logic [31:0] x);
        logic [31:0] xv;
        logic [63:0] m;
        logic [63:0] r;
        int e;
        int i;
        xv = (x == 32'd0) ? 32'd1 : x;
        e = 0;
        for (i = 0; i < 32; i++) begin
            if (xv[i]) e = i;
        end
        m = 64'(xv) << (30 - e);
        r = 64'(e) << 24;
        for (i = 23; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                r[i] = 1'b1;
            end
        end
        return r;
    endfunction

    // restoring divide, elaboration use only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] rem;
        int i;
        q = '0;
        rem = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[62:0], n[i]};
            if (rem >= d) begin
                rem = rem - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Beta equation (B 3435, T0 25 C), degrees C in Q.frac_bits
    function automatic logic [FILT_W-1:0] rom_temp(input int adc_bits, input int frac_bits,
                                                   input int code);
        logic [63:0] full;
        logic [63:0] v;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] mag;
        logic [63:0] lnmag;
        logic [63:0] dmag;
        logic [63:0] base;
        logic [63:0] num;
        logic        neg;
        longint      tinv;
        longint      tk;
        longint      off;
        longint      t;
        full = 64'd1 << adc_bits;
        v = 64'(code) & (full - 64'd1);
        if (v == 64'd0) v = 64'd1;
        a = log2_q24(32'(full - v));
        b = log2_q24(32'(v));
        neg = a < b;
        mag = neg ? b - a : a - b;
        lnmag = (mag * LN2_Q30 + (64'd1 << 29)) >> 30;
        dmag = ((lnmag << 16) + 64'd1717) / 64'd3435;
        base = (64'd100 << 40) / 64'd29815;
        tinv = neg ? longint'(base) - longint'(dmag) : longint'(base) + longint'(dmag);
        if (tinv < 1) tinv = 1;
        num = (64'd1 << (40 + frac_bits)) + (64'(tinv) >> 1);
        tk = longint'(udiv64(num, 64'(tinv)));
        off = longint'(((64'd27315 << frac_bits) + 64'd50) / 64'd100);
        t = tk - off;
        if (t > FILT_MAX_L) t = FILT_MAX_L;
        if (t < FILT_MIN_L) t = FILT_MIN_L;
        return t[FILT_W-1:0];
    endfunction

endpackage

### src/thermistor_temperature_monitor.sv
// NTC thermistor monitor: table lookup, IIR filter, publish and change event.
// Items pass through a four-step in-order pipeline: table read (synchronous ROM of
// 2**ADC_BITS entries of 20 bits, filled at elaboration), filter multiply, filter
// and tick update, then publish and bus response into the output register. Bus
// items (reads, poll, clear) enter one per cycle when nothing stalls; two sample
// ticks may enter back to back, after which a sample waits in s1, as its multiply
// must see the filter value written back by the sample before it. A result passes
// through the s1, s2 and s3 registers into the output register. There is no
// clearing pass after reset.
module thermistor_temperature_monitor
    import ttm_pkg::*;
#(
    parameter int ADC_BITS  = 10,
    parameter int FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [2:0]           i_func,
    input  logic [ADC_BITS-1:0]  i_adc_sample,
    input  logic [7:0]           i_event_code,
    input  logic [DATA_W-1:0]    i_event_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [DATA_W-1:0]    o_read_data,
    output logic                 o_event_present,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    localparam int ROM_DEPTH = 2 ** ADC_BITS;
    localparam int ROM_BITS  = ROM_DEPTH * FILT_W;
    localparam int STEP_W    = PROD_W - DATA_W;
    localparam int SUM_W     = STEP_W + 1;
    localparam int TEN_W     = FILT_W + 4;

    function automatic logic [ROM_BITS-1:0] build_rom();
        logic [ROM_BITS-1:0] img;
        int c;
        img = '0;
        for (c = 0; c < ROM_DEPTH; c++) begin
            img[c*FILT_W +: FILT_W] = rom_temp(ADC_BITS, FRAC_BITS, c);
        end
        return img;
    endfunction

    localparam logic [ROM_BITS-1:0] ROM_IMAGE = build_rom();

    // configuration
    logic [DATA_W-1:0] r_alpha;
    logic [DATA_W-1:0] r_period;

    // architectural state
    logic signed [FILT_W-1:0] r_filt;
    logic [DATA_W-1:0]        r_published;
    logic [DATA_W-1:0]        r_acked;
    logic [DATA_W-1:0]        r_tick;
    logic                     r_started;
    logic [ADC_BITS-1:0]      r_raw;

    // pipeline
    logic                     r_s1_valid;
    logic [2:0]               r_s1_func;
    logic [ADC_BITS-1:0]      r_s1_raw;
    logic [7:0]               r_s1_code;
    logic [DATA_W-1:0]        r_s1_data;
    logic signed [FILT_W-1:0] r_s1_temp;

    logic                     r_s2_valid;
    logic [2:0]               r_s2_func;
    logic [ADC_BITS-1:0]      r_s2_raw;
    logic [7:0]               r_s2_code;
    logic [DATA_W-1:0]        r_s2_data;
    logic signed [FILT_W-1:0] r_s2_temp;
    logic signed [PROD_W-1:0] r_s2_prod;

    logic                     r_s3_valid;
    logic [2:0]               r_s3_func;
    logic [ADC_BITS-1:0]      r_s3_raw;
    logic [7:0]               r_s3_code;
    logic [DATA_W-1:0]        r_s3_data;
    logic signed [FILT_W-1:0] r_s3_filt;
    logic                     r_s3_pub;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_event;

    // flow control
    logic in_accept, out_ready;
    logic s3_result, s3_commit, s3_free;
    logic s2_move, s2_free, s2_sample;
    logic s1_move, s1_free, s1_sample;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign s3_result = (r_s3_func == FN_READ_TEMP) || (r_s3_func == FN_READ_RAW) ||
                       (r_s3_func == FN_POLL);
    assign s3_commit = r_s3_valid && (!s3_result || out_ready);
    assign s3_free   = !r_s3_valid || s3_commit;
    assign s2_move   = r_s2_valid && s3_free;
    assign s2_free   = !r_s2_valid || s2_move;
    assign s2_sample = r_s2_valid && (r_s2_func == FN_SAMPLE);
    assign s1_sample = r_s1_valid && (r_s1_func == FN_SAMPLE);
    // a sample waits in s1 while the previous sample has yet to write the filter
    assign s1_move   = r_s1_valid && s2_free && !(s1_sample && s2_sample);
    assign s1_free   = !r_s1_valid || s1_move;

    assign o_in_stall  = !s1_free || !i_rst_n;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = i_rst_n;

    // s1: filter difference times alpha
    logic signed [FILT_W:0]   s1_diff;
    logic signed [PROD_W-1:0] s1_prod;
    assign s1_diff = {r_s1_temp[FILT_W-1], r_s1_temp} - {r_filt[FILT_W-1], r_filt};
    assign s1_prod = s1_diff * $signed({1'b0, r_alpha});

    // s2: filter and tick update (arithmetic shift gives the floor)
    logic signed [STEP_W-1:0] s2_step;
    logic signed [SUM_W-1:0]  s2_sum;
    logic signed [FILT_W-1:0] s2_sat;
    logic signed [FILT_W-1:0] n_filt;
    logic [DATA_W-1:0]        s2_tick_inc;
    logic [DATA_W-1:0]        n_tick;
    logic                     n_pub;

    assign s2_step = r_s2_prod[PROD_W-1:DATA_W];
    assign s2_sum  = {{(SUM_W-FILT_W){r_filt[FILT_W-1]}}, r_filt} +
                     {s2_step[STEP_W-1], s2_step};

    always_comb begin
        if (s2_sum > SUM_W'(FILT_MAX_L)) begin
            s2_sat = {1'b0, {(FILT_W-1){1'b1}}};
        end else if (s2_sum < SUM_W'(FILT_MIN_L)) begin
            s2_sat = {1'b1, {(FILT_W-1){1'b0}}};
        end else begin
            s2_sat = s2_sum[FILT_W-1:0];
        end
        s2_tick_inc = (r_tick == '1) ? r_tick : r_tick + 1'b1;
        if (!r_started) begin
            n_filt = r_s2_temp;
            n_tick = '0;
            n_pub  = 1'b1;
        end else if (s2_tick_inc > r_period) begin
            n_filt = s2_sat;
            n_tick = '0;
            n_pub  = 1'b1;
        end else begin
            n_filt = s2_sat;
            n_tick = s2_tick_inc;
            n_pub  = 1'b0;
        end
    end

    // s3: tenths = trunc(filt * 10), saturated to int16
    logic signed [TEN_W-1:0] s3_ext;
    logic signed [TEN_W-1:0] s3_p;
    logic [TEN_W-1:0]        s3_mag;
    logic [TEN_W-1:0]        s3_q;
    logic [DATA_W-1:0]       n_published;
    logic [DATA_W-1:0]       s3_rd_data;
    logic                    s3_rd_event;
    logic                    s3_event;

    assign s3_ext = {{(TEN_W-FILT_W){r_s3_filt[FILT_W-1]}}, r_s3_filt};
    assign s3_p   = (s3_ext <<< 3) + (s3_ext <<< 1);
    assign s3_mag = s3_p[TEN_W-1] ? TEN_W'(-s3_p) : TEN_W'(s3_p);
    assign s3_q   = s3_mag >> FRAC_BITS;

    always_comb begin
        if (!s3_p[TEN_W-1]) begin
            n_published = (s3_q > TEN_W'(32767)) ? 16'h7fff : s3_q[DATA_W-1:0];
        end else begin
            n_published = (s3_q > TEN_W'(32768)) ? 16'h8000 : (~s3_q[DATA_W-1:0] + 1'b1);
        end
    end

    assign s3_event = r_published != r_acked;

    always_comb begin
        s3_rd_data  = '0;
        s3_rd_event = 1'b0;
        case (r_s3_func)
            FN_READ_TEMP: s3_rd_data = r_published;
            FN_READ_RAW:  s3_rd_data = {{(DATA_W-ADC_BITS){1'b0}}, r_raw};
            FN_POLL: begin
                s3_rd_data  = s3_event ? r_published : '0;
                s3_rd_event = s3_event;
            end
            default: ;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= ALPHA_RST;
            r_period <= PERIOD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ALPHA:  r_alpha  <= i_cfg_data;
                CFG_PERIOD: r_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept)    r_s1_valid <= 1'b1;
            else if (s1_move) r_s1_valid <= 1'b0;
            if (s1_move)      r_s2_valid <= 1'b1;
            else if (s2_move) r_s2_valid <= 1'b0;
            if (s2_move)        r_s3_valid <= 1'b1;
            else if (s3_commit) r_s3_valid <= 1'b0;
            if (s3_commit && s3_result) r_out_valid <= 1'b1;
            else if (!i_out_stall)      r_out_valid <= 1'b0;
        end
    end

    // pipeline payload; the table read is registered at the input transfer
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_func <= i_func;
            r_s1_raw  <= i_adc_sample;
            r_s1_code <= i_event_code;
            r_s1_data <= i_event_data;
            r_s1_temp <= ROM_IMAGE[i_adc_sample*FILT_W +: FILT_W];
        end
        if (s1_move) begin
            r_s2_func <= r_s1_func;
            r_s2_raw  <= r_s1_raw;
            r_s2_code <= r_s1_code;
            r_s2_data <= r_s1_data;
            r_s2_temp <= r_s1_temp;
            r_s2_prod <= s1_prod;
        end
        if (s2_move) begin
            r_s3_func <= r_s2_func;
            r_s3_raw  <= r_s2_raw;
            r_s3_code <= r_s2_code;
            r_s3_data <= r_s2_data;
            r_s3_filt <= n_filt;
            r_s3_pub  <= n_pub;
        end
        if (s3_commit && s3_result) begin
            r_out_data  <= s3_rd_data;
            r_out_event <= s3_rd_event;
        end
    end

    // state write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt      <= '0;
            r_tick      <= '0;
            r_started   <= 1'b0;
            r_published <= '0;
            r_acked     <= '0;
            r_raw       <= '0;
        end else begin
            if (s2_move && s2_sample) begin
                r_filt    <= n_filt;
                r_tick    <= n_tick;
                r_started <= 1'b1;
            end
            if (s3_commit && (r_s3_func == FN_SAMPLE)) begin
                r_raw <= r_s3_raw;
                if (r_s3_pub) r_published <= n_published;
            end
            if (s3_commit && (r_s3_func == FN_CLEAR) && (r_s3_code == EV_TEMP_CHANGE) &&
                (r_s3_data == r_published)) begin
                r_acked <= r_s3_data;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_out_data;
    assign o_event_present = r_out_event;

endmodule

### src/ttm_checker.sv
// Port-level checks for the thermistor monitor, bound to the top level.
module ttm_checker
    import ttm_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic [2:0]           i_func,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [DATA_W-1:0]    o_read_data,
    input logic                 o_event_present,
    input logic                 o_cfg_ready
);

    logic sample_xfer;
    assign sample_xfer = i_in_valid && !o_in_stall && (i_func == FN_SAMPLE);

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_read_data) && $stable(o_event_present))
        else $error("stalled result changed");

    // filter write-back interlock: no three sample transfers in a row
    a_sample_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sample_xfer ##1 sample_xfer |=> !sample_xfer)
        else $error("sample taken before filter write-back");

    // no configuration transfer is taken while held in reset
    a_cfg_reset: assert property (@(posedge i_clk) !i_rst_n |-> !o_cfg_ready)
        else $error("configuration ready during reset");

endmodule

bind thermistor_temperature_monitor ttm_checker u_ttm_checker (.*);
